FILE: rtl/swrl_pkg.sv
package swrl_pkg;

	localparam int WIN_W      = 31;
	localparam int LIMIT_W    = 9;
	localparam int DROP_W     = 32;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [WIN_W-1:0]   WINDOW_RESET = 31'd1000000;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 9'd200;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_TICKS   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PER_WINDOW = 8'd1;

	typedef struct packed {
		logic load_now;
		logic rd_head;
		logic pop;
		logic push;
		logic drop;
	} swrl_cmd_t;

	typedef struct packed {
		logic empty;
		logic expired;
		logic full;
	} swrl_sts_t;

endpackage

FILE: rtl/swrl_dp.sv
module swrl_dp #(
	parameter int DEPTH      = 256,
	parameter int STAMP_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  swrl_pkg::swrl_cmd_t                 cmd,
	output swrl_pkg::swrl_sts_t                 sts,
	input  logic [STAMP_BITS-1:0]               arrival_time,
	input  logic                                cfg_we,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                allowed,
	output logic [swrl_pkg::DROP_W-1:0]         dropped_report
);

	localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int CMP_W   = (STAMP_BITS > swrl_pkg::WIN_W) ? STAMP_BITS : swrl_pkg::WIN_W;
	localparam int LCMP_W  = (CNT_W > swrl_pkg::LIMIT_W) ? CNT_W : swrl_pkg::LIMIT_W;

	logic [STAMP_BITS-1:0]            stamp_mem [DEPTH];
	logic [STAMP_BITS-1:0]            head_stamp_q;
	logic [STAMP_BITS-1:0]            now_q;
	logic [ADDR_W-1:0]                head_q;
	logic [ADDR_W-1:0]                tail_q;
	logic [CNT_W-1:0]                 count_q;
	logic [swrl_pkg::DROP_W-1:0]      drop_q;
	logic [swrl_pkg::WIN_W-1:0]       window_ticks_q;
	logic [swrl_pkg::LIMIT_W-1:0]     max_per_window_q;
	logic [swrl_pkg::DROP_W-1:0]      dropped_report_q;
	logic                             allowed_q;
	logic [STAMP_BITS-1:0]            age;

	function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] i);
		next_slot = (i == ADDR_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

	assign age         = now_q - head_stamp_q;
	assign sts.empty   = (count_q == '0);
	assign sts.expired = CMP_W'(age) >= CMP_W'(window_ticks_q);
	// A limit above the FIFO depth behaves as the depth itself.
	assign sts.full    = (count_q == CNT_W'(DEPTH)) ||
		(LCMP_W'(count_q) >= LCMP_W'(max_per_window_q));

	assign allowed        = allowed_q;
	assign dropped_report = dropped_report_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			stamp_mem[tail_q] <= now_q;
		end
		if (cmd.rd_head) begin
			head_stamp_q <= stamp_mem[head_q];
		end
		if (cmd.load_now) begin
			now_q <= arrival_time;
		end
		if (cmd.push) begin
			allowed_q        <= 1'b1;
			dropped_report_q <= drop_q;
		end else if (cmd.drop) begin
			allowed_q        <= 1'b0;
			dropped_report_q <= '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q           <= '0;
			tail_q           <= '0;
			count_q          <= '0;
			drop_q           <= '0;
			window_ticks_q   <= swrl_pkg::WINDOW_RESET;
			max_per_window_q <= swrl_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					swrl_pkg::REG_WINDOW_TICKS: begin
						window_ticks_q <= cfg_data[swrl_pkg::WIN_W-1:0];
					end
					swrl_pkg::REG_MAX_PER_WINDOW: begin
						max_per_window_q <= cfg_data[swrl_pkg::LIMIT_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (cmd.pop) begin
				head_q  <= next_slot(head_q);
				count_q <= count_q - 1'b1;
			end else if (cmd.push) begin
				tail_q  <= next_slot(tail_q);
				count_q <= count_q + 1'b1;
				drop_q  <= '0;
			end else if (cmd.drop && (drop_q != '1)) begin
				drop_q <= drop_q + 1'b1;
			end
		end
	end

endmodule

FILE: rtl/swrl_ctrl.sv
module swrl_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	output logic                res_valid,
	input  logic                res_stall,
	input  swrl_pkg::swrl_sts_t sts,
	output swrl_pkg::swrl_cmd_t cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_CHECK
	} state_t;

	state_t state_q;
	logic   res_valid_q;
	logic   slot_free;
	logic   do_pop;
	logic   decide;

	assign slot_free = !res_valid_q || !res_stall;
	assign do_pop    = (state_q == S_CHECK) && !sts.empty && sts.expired;
	assign decide    = (state_q == S_CHECK) && !do_pop && slot_free;

	assign req_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;

	always_comb begin
		cmd          = '0;
		cmd.load_now = (state_q == S_IDLE) && req_valid;
		cmd.rd_head  = (state_q == S_READ);
		cmd.pop      = do_pop;
		cmd.push     = decide && !sts.full;
		cmd.drop     = decide && sts.full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			if (decide) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CHECK;
				end
				S_CHECK: begin
					// Each expired head entry costs one pop and one fresh head read.
					if (do_pop) begin
						state_q <= S_READ;
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/sliding_window_rate_limiter.sv
// Sliding-log rate limiter.
// The request channel (req_valid, req_stall, arrival_time) carries one request
// stamp; it is taken at an edge where req_valid is high and req_stall is low.
// The result channel (res_valid, res_stall, allowed, dropped_report) returns
// exactly one result per request: allowed = 1 with the number of requests
// dropped since the previous allowed one, or allowed = 0 with a zero report.
// Registers: index 0 is window_ticks, index 1 is max_per_window, written on
// the cfg channel when cfg_valid and cfg_ready are high; other indexes are
// ignored. Write them only while no request is in flight.
// Flow: a taken request reads the head stamp and is checked; each stored stamp
// that has aged out of the window is popped and the new head read, one at a
// time through the single read port of the stamp memory. The result is valid
// in the cycle after the decision and the next request can be taken then.
// A result waits in its output register while res_stall is high, and the
// block still takes and processes the next request up to its decision.
// Reset clears the FIFO pointers, the fill count and the drop counter, and
// loads window_ticks = 1000000 and max_per_window = 200; no clearing pass.
module sliding_window_rate_limiter #(
	parameter int DEPTH      = 256,
	parameter int STAMP_BITS = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            req_valid,
	output logic                            req_stall,
	input  logic [STAMP_BITS-1:0]           arrival_time,
	output logic                            res_valid,
	input  logic                            res_stall,
	output logic                            allowed,
	output logic [swrl_pkg::DROP_W-1:0]     dropped_report,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data
);

	swrl_pkg::swrl_cmd_t cmd;
	swrl_pkg::swrl_sts_t sts;

	assign cfg_ready = 1'b1;

	swrl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	swrl_dp #(
		.DEPTH      (DEPTH),
		.STAMP_BITS (STAMP_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.arrival_time   (arrival_time),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.allowed        (allowed),
		.dropped_report (dropped_report)
	);

endmodule

FILE: rtl/swrl_checker.sv
module swrl_checker #(
	parameter int STAMP_BITS = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_stall,
	input logic [STAMP_BITS-1:0]       arrival_time,
	input logic                        res_valid,
	input logic                        res_stall,
	input logic                        allowed,
	input logic [swrl_pkg::DROP_W-1:0] dropped_report
);

	// A refused request never reports a drop count.
	a_drop_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !allowed |-> dropped_report == '0)
		else $error("refused request carries a nonzero drop report");

	// The block handles one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken while another is in work");

	// A request held off by stall stays offered and unchanged.
	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(arrival_time))
		else $error("stalled request withdrawn or changed");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("stalled result withdrawn");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(allowed) && $stable(dropped_report))
		else $error("stalled result changed");

endmodule

bind sliding_window_rate_limiter swrl_checker #(
	.STAMP_BITS (STAMP_BITS)
) u_swrl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req_valid),
	.req_stall      (req_stall),
	.arrival_time   (arrival_time),
	.res_valid      (res_valid),
	.res_stall      (res_stall),
	.allowed        (allowed),
	.dropped_report (dropped_report)
);

FILE: verif/sliding_window_rate_limiter_tb.sv
class rate_scoreboard;
	typedef struct packed {
		logic                        allowed;
		logic [swrl_pkg::DROP_W-1:0] report;
	} verdict_t;

	// Mirror of the limiter state.
	logic [31:0]                  stamps [256];
	logic [7:0]                   head;
	logic [7:0]                   tail;
	int unsigned                  fill;
	logic [swrl_pkg::DROP_W-1:0]  drops;
	logic [swrl_pkg::WIN_W-1:0]   window;
	logic [swrl_pkg::LIMIT_W-1:0] limit;

	verdict_t verdict_q [$];
	int       failures;

	function new();
		head     = '0;
		tail     = '0;
		fill     = 0;
		drops    = '0;
		window   = swrl_pkg::WINDOW_RESET;
		limit    = swrl_pkg::LIMIT_RESET;
		failures = 0;
	endfunction

	function void set_register(logic [swrl_pkg::CFG_IDX_W-1:0] idx,
			logic [swrl_pkg::CFG_DATA_W-1:0] data);
		case (idx)
			swrl_pkg::REG_WINDOW_TICKS: begin
				window = data[swrl_pkg::WIN_W-1:0];
			end
			swrl_pkg::REG_MAX_PER_WINDOW: begin
				limit = data[swrl_pkg::LIMIT_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Expires old stamps, then admits or refuses the request.
	function void note_request(logic [31:0] now);
		int unsigned cap;
		logic [31:0] age;
		verdict_t    v;
		cap = (limit > 256) ? 256 : limit;
		while (fill > 0) begin
			age = now - stamps[head];
			if (age < {1'b0, window})
				break;
			head = head + 8'd1;
			fill--;
		end
		if (fill >= cap) begin
			if (drops != '1)
				drops = drops + 1'b1;
			v.allowed = 1'b0;
			v.report  = '0;
		end else begin
			stamps[tail] = now;
			tail         = tail + 8'd1;
			fill++;
			v.allowed = 1'b1;
			v.report  = drops;
			drops     = '0;
		end
		verdict_q.push_back(v);
	endfunction

	function void flag(string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function void check_verdict(logic allowed, logic [swrl_pkg::DROP_W-1:0] report);
		verdict_t v;
		if (verdict_q.size() == 0) begin
			flag($sformatf("result with no request waiting: allowed=%0d report=%0d",
				allowed, report));
		end else begin
			v = verdict_q[0];
			verdict_q.delete(0);
			if (allowed !== v.allowed || report !== v.report)
				flag($sformatf({"mismatch: expected allowed=%0d report=%0d, ",
					"got allowed=%0d report=%0d"},
					v.allowed, v.report, allowed, report));
		end
	endfunction

	function int pending();
		return verdict_q.size();
	endfunction
endclass

module sliding_window_rate_limiter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FIFO_DEPTH = 256;
	localparam logic [30:0] WINDOW_MAX = 31'h7FFF_FFFF;

	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	logic [31:0]                     arrival_time;
	logic                            res_valid;
	logic                            res_stall;
	logic                            allowed;
	logic [swrl_pkg::DROP_W-1:0]     dropped_report;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [swrl_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [swrl_pkg::CFG_DATA_W-1:0] cfg_data;

	rate_scoreboard sb = new();

	bit quiet;
	bit hold_off_req;

	sliding_window_rate_limiter #(
		.DEPTH(FIFO_DEPTH),
		.STAMP_BITS(32)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.arrival_time(arrival_time),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.allowed(allowed),
		.dropped_report(dropped_report),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall)
				sb.note_request(arrival_time);
			if (cfg_valid && cfg_ready)
				sb.set_register(cfg_index, cfg_data);
			if (res_valid && !res_stall)
				sb.check_verdict(allowed, dropped_report);
		end
	end

	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 80);
	endfunction

	// Result side: random stalls, plus one long hold-off on demand.
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				n = 400;
			end else begin
				n = pick_idle();
			end
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
			end
			res_stall <= 1'b0;
			repeat (pick_idle()) @(negedge clk);
		end
	end

	// Called just after a falling edge; returns just after the falling edge
	// that follows acceptance, with req_valid still high.
	task automatic send_request(input logic [31:0] stamp);
		req_valid    <= 1'b1;
		arrival_time <= stamp;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic sender_idle(input int n);
		if (n > 0) begin
			req_valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic write_reg(input logic [swrl_pkg::CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Writes both registers in random order, sometimes with a write to an
	// unmapped index mixed in. Only called while nothing is in flight.
	task automatic configure(input logic [31:0] win_word, input logic [31:0] lim_word);
		int unsigned spare;
		if ($urandom_range(0, 1)) begin
			write_reg(swrl_pkg::REG_WINDOW_TICKS, win_word);
			write_reg(swrl_pkg::REG_MAX_PER_WINDOW, lim_word);
		end else begin
			write_reg(swrl_pkg::REG_MAX_PER_WINDOW, lim_word);
			write_reg(swrl_pkg::REG_WINDOW_TICKS, win_word);
		end
		if ($urandom_range(0, 2) == 0) begin
			spare = $urandom_range(swrl_pkg::REG_MAX_PER_WINDOW + 1, 255);
			write_reg(spare[swrl_pkg::CFG_IDX_W-1:0], $urandom);
		end
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [31:0] next_stamp(logic [31:0] prev, int unsigned win,
			int unsigned cap, bit noisy, bit dense);
		int unsigned r;
		int unsigned span;
		r = $urandom_range(0, 99);
		if (noisy && r < 8)
			return $urandom;
		if (dense)
			return prev + ((r < 99) ? $urandom_range(0, 3) : win);
		span = (cap == 0) ? win : win / cap;
		if (r < 60)
			return prev + $urandom_range(0, span);
		if (r < 90)
			return prev + $urandom_range(0, span / 4);
		if (r < 98)
			return prev + $urandom_range(0, win);
		return prev + $urandom_range(win, 2 * win);
	endfunction

	task automatic send_list(input logic [31:0] stamps[$]);
		foreach (stamps[i]) begin
			send_request(stamps[i]);
			sender_idle(pick_idle());
		end
	endtask

	initial begin
		logic [31:0] prev;
		int unsigned win;
		int unsigned lim;
		int unsigned cap;
		int          count;
		bit          noisy;
		bit          dense;

		arst_n       = 1'b0;
		req_valid    = 1'b0;
		arrival_time = '0;
		cfg_valid    = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		quiet        = 1'b0;
		hold_off_req = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Reset settings: wrap of the stamp, then an earlier stamp that
		// looks very old and expires everything.
		send_list('{32'h0, 32'hFFFF_FFFF, 32'h5, 32'h8000_0000, 32'h7000_0000});
		drain();

		// Two per 100 ticks: drops, then expiry frees a slot and the drop
		// count is reported.
		configure(32'd100, 32'd2);
		send_list('{32'd1000, 32'd1001, 32'd1002, 32'd1003, 32'd1100, 32'd1200});
		drain();

		// Zero limit, set with the upper data bits high: everything refused.
		configure(32'd100, 32'hFFFF_FE00);
		send_list('{32'd5, 32'd6});
		drain();

		// Zero window with limit one: each entry expires before the check.
		configure(32'h8000_0000, 32'd1);
		send_list('{32'd7, 32'd7, 32'd3});
		drain();

		// Largest window, limit above the FIFO depth.
		configure(32'hFFFF_FFFF, 32'h0000_01FF);
		send_list('{32'h0, 32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'hFFFF_FFFF});
		drain();

		for (int ph = 0; ph < 7; ph++) begin
			noisy = 1'b0;
			dense = 1'b0;
			count = 70;
			case (ph)
				0: begin
					win   = $urandom_range(1, 64);
					lim   = $urandom_range(1, 8);
					noisy = 1'b1;
				end
				1: begin
					win = 0;
					lim = $urandom_range(0, 3);
				end
				2: begin
					win = WINDOW_MAX;
					lim = 1;
				end
				3: begin
					win   = $urandom_range(1, WINDOW_MAX);
					lim   = $urandom_range(1, 511);
					noisy = 1'b1;
				end
				4: begin
					win = 1;
					lim = 256;
				end
				5: begin
					win = $urandom_range(100, 5000);
					lim = $urandom_range(16, 64);
				end
				default: begin
					win   = $urandom_range(32'h0010_0000, WINDOW_MAX);
					lim   = $urandom_range(256, 511);
					dense = 1'b1;
					count = 300;
				end
			endcase
			cap   = (lim > 256) ? 256 : lim;
			quiet = (ph == 2);
			configure({1'($urandom), 31'(win)}, {23'($urandom), 9'(lim)});
			prev = $urandom;
			for (int i = 0; i < count; i++) begin
				// The dense phase fills the FIFO; a long result hold-off there
				// backs the block up into its request side.
				if (dense && i == 10)
					hold_off_req = 1'b1;
				if (ph == 5 && i == count / 2)
					drain();
				prev = next_stamp(prev, win, cap, noisy, dense);
				send_request(prev);
				sender_idle(pick_idle());
			end
			quiet = 1'b0;
			drain();
		end
		// Drop count saturation needs billions of refusals and is out of reach here.

		repeat (20) @(negedge clk);
		if (sb.failures == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#30_000_000;
		$display("tb: failure");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/swrl_pkg.sv
rtl/swrl_dp.sv
rtl/swrl_ctrl.sv
rtl/sliding_window_rate_limiter.sv
rtl/swrl_checker.sv
verif/sliding_window_rate_limiter_tb.sv
